@@ design/hidkb_pkg.sv @@
// Shared types, constants and the usage translation function for the HID
// keyboard report decoder. No dependencies; every other design file uses it.
package hidkb_pkg;

  // Fixed report layout of the boot protocol.
  localparam int KEY_SLOTS = 6;
  localparam int SlotW = $clog2(KEY_SLOTS);

  // Default depth of the key-code ring.
  localparam int RING_DEPTH_DEFAULT = 64;

  // Entries in the command queue between front and back.
  localparam int CmdFifoDepth = 2;

  // Either shift modifier selects the shifted table.
  localparam logic [7:0] ShiftMask = 8'h22;

  // Navigation usages and the codes they produce.
  localparam logic [7:0] UsgRight    = 8'h4F;
  localparam logic [7:0] UsgLeft     = 8'h50;
  localparam logic [7:0] UsgDown     = 8'h51;
  localparam logic [7:0] UsgUp       = 8'h52;
  localparam logic [7:0] UsgHome     = 8'h4A;
  localparam logic [7:0] UsgEnd      = 8'h4D;
  localparam logic [7:0] UsgPageUp   = 8'h4B;
  localparam logic [7:0] UsgPageDown = 8'h4E;
  localparam logic [7:0] UsgDelete   = 8'h4C;

  localparam logic [7:0] CodeRight    = 8'h83;
  localparam logic [7:0] CodeLeft     = 8'h82;
  localparam logic [7:0] CodeDown     = 8'h81;
  localparam logic [7:0] CodeUp       = 8'h80;
  localparam logic [7:0] CodeHome     = 8'h85;
  localparam logic [7:0] CodeEnd      = 8'h86;
  localparam logic [7:0] CodePageUp   = 8'h87;
  localparam logic [7:0] CodePageDown = 8'h88;
  localparam logic [7:0] CodeDelete   = 8'h84;
  localparam logic [7:0] CodeF1       = 8'h90;

  // One poll request.
  typedef struct packed {
    logic       report_ready;
    logic [7:0] modifiers;
    logic [7:0] key_0;
    logic [7:0] key_1;
    logic [7:0] key_2;
    logic [7:0] key_3;
    logic [7:0] key_4;
    logic [7:0] key_5;
  } hidkb_in_t;

  // One poll result.
  typedef struct packed {
    logic       code_valid;
    logic [7:0] key_code;
  } hidkb_out_t;

  // Classified poll handed from the front to the back.
  typedef struct packed {
    logic                          enabled;
    logic [KEY_SLOTS-1:0]          push;
    logic [KEY_SLOTS-1:0][7:0]     codes;
  } hidkb_cmd_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_POP
  } hidkb_state_e;

  // Translate a usage to a character, falling back to a navigation code.
  function automatic logic [7:0] hidkb_translate(input logic [7:0] usage,
                                                 input logic shifted);
    logic [7:0] c;
    c = 8'h00;
    case (usage) inside
      [8'h04:8'h1D]: c = (shifted ? 8'h41 : 8'h61) + (usage - 8'h04);
      [8'h1E:8'h26]: begin
        if (!shifted) begin
          c = 8'h31 + (usage - 8'h1E);
        end else begin
          case (usage)
            8'h1E:   c = 8'h21;
            8'h1F:   c = 8'h40;
            8'h20:   c = 8'h23;
            8'h21:   c = 8'h24;
            8'h22:   c = 8'h25;
            8'h23:   c = 8'h5E;
            8'h24:   c = 8'h26;
            8'h25:   c = 8'h2A;
            default: c = 8'h28;
          endcase
        end
      end
      8'h27: c = shifted ? 8'h29 : 8'h30;
      8'h28: c = 8'h0A;
      8'h29: c = 8'h1B;
      8'h2A: c = 8'h08;
      8'h2B: c = 8'h09;
      8'h2C: c = 8'h20;
      8'h2D: c = shifted ? 8'h5F : 8'h2D;
      8'h2E: c = shifted ? 8'h2B : 8'h3D;
      8'h2F: c = shifted ? 8'h7B : 8'h5B;
      8'h30: c = shifted ? 8'h7D : 8'h5D;
      8'h31: c = shifted ? 8'h7C : 8'h5C;
      8'h33: c = shifted ? 8'h3A : 8'h3B;
      8'h34: c = shifted ? 8'h22 : 8'h27;
      8'h35: c = shifted ? 8'h7E : 8'h60;
      8'h36: c = shifted ? 8'h3C : 8'h2C;
      8'h37: c = shifted ? 8'h3E : 8'h2E;
      8'h38: c = shifted ? 8'h3F : 8'h2F;
      [8'h3A:8'h3E]: c = CodeF1 + (usage - 8'h3A);
      default: c = 8'h00;
    endcase
    if (c == 8'h00) begin
      case (usage)
        UsgRight:    c = CodeRight;
        UsgLeft:     c = CodeLeft;
        UsgDown:     c = CodeDown;
        UsgUp:       c = CodeUp;
        UsgHome:     c = CodeHome;
        UsgEnd:      c = CodeEnd;
        UsgPageUp:   c = CodePageUp;
        UsgPageDown: c = CodePageDown;
        UsgDelete:   c = CodeDelete;
        default:     c = 8'h00;
      endcase
    end
    return c;
  endfunction

endpackage

@@ design/hidkb_front.sv @@
// Front end: accepts poll requests, finds newly pressed keys against the
// previous report and translates them. Depends on hidkb_pkg.
module hidkb_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hidkb_pkg::hidkb_in_t in_data_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output hidkb_pkg::hidkb_cmd_t cmd_o
);

  logic                 present_q;
  logic [7:0]           prev_q [hidkb_pkg::KEY_SLOTS];
  logic [7:0]           keys   [hidkb_pkg::KEY_SLOTS];
  logic                 shifted;
  logic                 accept;
  logic                 take_report;

  // Unpack the report's key slots.
  assign keys[0] = in_data_i.key_0;
  assign keys[1] = in_data_i.key_1;
  assign keys[2] = in_data_i.key_2;
  assign keys[3] = in_data_i.key_3;
  assign keys[4] = in_data_i.key_4;
  assign keys[5] = in_data_i.key_5;

  assign shifted     = (in_data_i.modifiers & hidkb_pkg::ShiftMask) != 8'h00;
  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign accept      = in_valid_i && cmd_ready_i;
  assign take_report = present_q && in_data_i.report_ready;

  // Classify every slot: when enabled and the poll carries a report, a nonzero
  // usage absent from the previous report with a nonzero translation is pushed.
  always_comb begin
    logic held;
    logic [7:0] code;
    cmd_o = '0;
    cmd_o.enabled = present_q;
    for (int i = 0; i < hidkb_pkg::KEY_SLOTS; i++) begin
      held = 1'b0;
      for (int j = 0; j < hidkb_pkg::KEY_SLOTS; j++) begin
        if (prev_q[j] == keys[i]) begin
          held = 1'b1;
        end
      end
      code = hidkb_pkg::hidkb_translate(keys[i], shifted);
      cmd_o.codes[i] = code;
      cmd_o.push[i]  = take_report && (keys[i] != 8'h00) && !held &&
                       (code != 8'h00);
    end
  end

  // Keyboard enable register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
    end else if (cfg_we_i) begin
      present_q <= cfg_wdata_i;
    end
  end

  // Keep the usages of each accepted report while the keyboard is enabled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < hidkb_pkg::KEY_SLOTS; k++) begin
        prev_q[k] <= 8'h00;
      end
    end else if (accept && take_report) begin
      for (int k = 0; k < hidkb_pkg::KEY_SLOTS; k++) begin
        prev_q[k] <= keys[k];
      end
    end
  end

endmodule

@@ design/hidkb_cmd_fifo.sv @@
// Short queue of classified polls between the front and the back end.
// Depends on hidkb_pkg.
module hidkb_cmd_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_valid_i,
  output logic                  wr_ready_o,
  input  hidkb_pkg::hidkb_cmd_t wr_data_i,
  output logic                  rd_valid_o,
  input  logic                  rd_ready_i,
  output hidkb_pkg::hidkb_cmd_t rd_data_o
);

  localparam int PtrW = $clog2(hidkb_pkg::CmdFifoDepth);
  localparam int CntW = $clog2(hidkb_pkg::CmdFifoDepth + 1);

  hidkb_pkg::hidkb_cmd_t entry_q [hidkb_pkg::CmdFifoDepth];
  logic [PtrW-1:0]       wr_ptr_q;
  logic [PtrW-1:0]       rd_ptr_q;
  logic [CntW-1:0]       count_q;
  logic                  do_wr;
  logic                  do_rd;

  assign wr_ready_o = count_q != CntW'(hidkb_pkg::CmdFifoDepth);
  assign rd_valid_o = count_q != '0;
  assign rd_data_o  = entry_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_ready_i && rd_valid_o;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(hidkb_pkg::CmdFifoDepth - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(hidkb_pkg::CmdFifoDepth - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ design/hidkb_back.sv @@
// Back end: writes the new codes of one poll into the key-code ring, one
// slot a cycle, then pops one code, if any waits and the keyboard is enabled,
// into the output register. Depends on hidkb_pkg.
module hidkb_back #(
  parameter int RING_DEPTH = hidkb_pkg::RING_DEPTH_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  hidkb_pkg::hidkb_cmd_t cmd_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hidkb_pkg::hidkb_out_t out_data_o
);

  localparam int PtrW = $clog2(RING_DEPTH);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(RING_DEPTH - 1);
  localparam logic [hidkb_pkg::SlotW-1:0] LastSlot =
    hidkb_pkg::SlotW'(hidkb_pkg::KEY_SLOTS - 1);

  hidkb_pkg::hidkb_state_e         state_q, state_d;
  hidkb_pkg::hidkb_cmd_t           cmd_q;
  logic [hidkb_pkg::SlotW-1:0]     slot_q;
  logic [PtrW-1:0]                 wp_q;
  logic [PtrW-1:0]                 rp_q;
  logic [PtrW-1:0]                 wp_next;
  logic [PtrW-1:0]                 rp_next;
  logic [7:0]                      ring_mem [RING_DEPTH];
  logic                            out_valid_q;
  logic                            code_valid_q;
  logic [7:0]                      key_code_q;
  logic                            out_free;
  logic                            ring_full;
  logic                            ring_empty;
  logic                            take_cmd;
  logic                            mem_we;
  logic                            load_out;
  logic                            rd_en;

  assign wp_next    = (wp_q == LastIdx) ? '0 : wp_q + 1'b1;
  assign rp_next    = (rp_q == LastIdx) ? '0 : rp_q + 1'b1;
  assign ring_full  = wp_next == rp_q;
  assign ring_empty = wp_q == rp_q;
  assign out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o           = out_valid_q;
  assign out_data_o.code_valid = code_valid_q;
  assign out_data_o.key_code   = key_code_q;
  assign cmd_ready_o           = take_cmd;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      hidkb_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = hidkb_pkg::ST_PUSH;
        end
      end
      hidkb_pkg::ST_PUSH: begin
        if (slot_q == LastSlot) begin
          state_d = hidkb_pkg::ST_POP;
        end
      end
      hidkb_pkg::ST_POP: begin
        if (out_free) begin
          state_d = hidkb_pkg::ST_IDLE;
        end
      end
      default: state_d = hidkb_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    take_cmd = 1'b0;
    mem_we   = 1'b0;
    load_out = 1'b0;
    rd_en    = 1'b0;
    case (state_q)
      hidkb_pkg::ST_IDLE: take_cmd = cmd_valid_i;
      hidkb_pkg::ST_PUSH: mem_we = cmd_q.push[slot_q] && !ring_full;
      hidkb_pkg::ST_POP: begin
        load_out = out_free;
        rd_en    = out_free && cmd_q.enabled && !ring_empty;
      end
      default: begin
        take_cmd = 1'b0;
      end
    endcase
  end

  // Sequencer state, slot counter and ring pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hidkb_pkg::ST_IDLE;
      slot_q  <= '0;
      wp_q    <= '0;
      rp_q    <= '0;
    end else begin
      state_q <= state_d;
      if (take_cmd) begin
        slot_q <= '0;
      end else if (state_q == hidkb_pkg::ST_PUSH) begin
        slot_q <= slot_q + 1'b1;
      end
      if (mem_we) begin
        wp_q <= wp_next;
      end
      if (rd_en) begin
        rp_q <= rp_next;
      end
    end
  end

  // Command being carried out.
  always_ff @(posedge clk_i) begin
    if (take_cmd) begin
      cmd_q <= cmd_i;
    end
  end

  // Ring storage; the read lands directly in the output code register.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[wp_q] <= cmd_q.codes[slot_q];
    end
    if (rd_en) begin
      key_code_q <= ring_mem[rp_q];
    end else if (load_out) begin
      key_code_q <= 8'h00;
    end
  end

  // Output register handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      code_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q  <= 1'b1;
        code_valid_q <= rd_en;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

@@ design/hid_keyboard_report_to_keycodes_core.sv @@
// Top level of the boot-protocol keyboard report decoder.
// Depends on hidkb_pkg, hidkb_front, hidkb_cmd_fifo and hidkb_back.

// Each poll request yields exactly one result. When the keyboard is enabled
// and the poll carries a report, every nonzero usage not present in the
// previous report is translated (shifted when either shift modifier is set,
// with navigation codes as fallback) and, if the translation is nonzero,
// appended to a ring of RING_DEPTH entries that holds at most RING_DEPTH-1
// codes and drops codes while full; then one code is popped if any waits.
// In the back end a poll is picked up, its key slots are written to the ring
// one after another through its single write port, and the ring is read
// into the output register. The front end classifies a request in the cycle
// it is accepted and a two-entry queue lets it run ahead of the back end.
// The ring has no reset; its pointers start empty.
module hid_keyboard_report_to_keycodes_core #(
  parameter int RING_DEPTH = hidkb_pkg::RING_DEPTH_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  hidkb_pkg::hidkb_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hidkb_pkg::hidkb_out_t out_data_o
);

  logic                  front_valid;
  logic                  front_ready;
  hidkb_pkg::hidkb_cmd_t front_cmd;
  logic                  back_valid;
  logic                  back_ready;
  hidkb_pkg::hidkb_cmd_t back_cmd;

  // Request classification.
  hidkb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  // Queue between the two halves.
  hidkb_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .wr_data_i  (front_cmd),
    .rd_valid_o (back_valid),
    .rd_ready_i (back_ready),
    .rd_data_o  (back_cmd)
  );

  // Ring update and result delivery.
  hidkb_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (back_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for hid_keyboard_report_to_keycodes_core.
// Depends on hidkb_pkg and the core. A scoreboard class predicts one key-code result
// per poll request. Tasks drive the request handshake and the enable register.
`timescale 1ns / 1ps

module tb;
  import hidkb_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 32;
  localparam int PRESSURE_HOLD = 400;
  localparam int RING_SLOTS    = RING_DEPTH_DEFAULT;

  // Tracks the enable bit, the last report's usages and the queued key codes,
  // and holds the result expected for every accepted poll request.
  class keycode_scoreboard;
    bit         kb_enabled;
    logic [7:0] held_keys [KEY_SLOTS];
    logic [7:0] ring_codes [$];
    hidkb_out_t codes_due [$];
    int         errors;

    function new();
      kb_enabled = 1'b0;
      foreach (held_keys[i]) held_keys[i] = 8'h00;
      errors = 0;
    endfunction

    function void set_enabled(bit on);
      kb_enabled = on;
    endfunction

    function int outstanding();
      return codes_due.size();
    endfunction

    // Character for a usage, or a navigation code when it has no character.
    function logic [7:0] usage_to_code(logic [7:0] usage, bit shifted);
      string      digits_lo = "1234567890";
      string      digits_hi = "!@#$%^&*()";
      string      punct_lo  = "-=[]\\ ;'`,./";
      string      punct_hi  = "_+{}| :\"~<>?";
      logic [7:0] c;
      c = 8'h00;
      if (usage >= 8'h04 && usage <= 8'h1D) begin
        c = (shifted ? 8'h41 : 8'h61) + (usage - 8'h04);
      end else if (usage >= 8'h1E && usage <= 8'h27) begin
        c = shifted ? digits_hi[usage - 8'h1E] : digits_lo[usage - 8'h1E];
      end else if (usage >= 8'h2D && usage <= 8'h38 && usage != 8'h32) begin
        c = shifted ? punct_hi[usage - 8'h2D] : punct_lo[usage - 8'h2D];
      end else if (usage >= 8'h3A && usage <= 8'h3E) begin
        c = CodeF1 + (usage - 8'h3A);
      end else begin
        case (usage)
          8'h28: c = 8'h0A;
          8'h29: c = 8'h1B;
          8'h2A: c = 8'h08;
          8'h2B: c = 8'h09;
          8'h2C: c = 8'h20;
          default: c = 8'h00;
        endcase
      end
      if (c == 8'h00) begin
        case (usage)
          UsgRight:    c = CodeRight;
          UsgLeft:     c = CodeLeft;
          UsgDown:     c = CodeDown;
          UsgUp:       c = CodeUp;
          UsgHome:     c = CodeHome;
          UsgEnd:      c = CodeEnd;
          UsgPageUp:   c = CodePageUp;
          UsgPageDown: c = CodePageDown;
          UsgDelete:   c = CodeDelete;
          default:     c = 8'h00;
        endcase
      end
      return c;
    endfunction

    // Apply one accepted poll request and queue the result it must produce.
    function void note_poll(hidkb_in_t p);
      logic [7:0] keys [KEY_SLOTS];
      hidkb_out_t want;
      logic [7:0] c;
      bit         shifted;
      bit         held;
      want = '0;
      if (kb_enabled) begin
        if (p.report_ready) begin
          keys[0] = p.key_0;
          keys[1] = p.key_1;
          keys[2] = p.key_2;
          keys[3] = p.key_3;
          keys[4] = p.key_4;
          keys[5] = p.key_5;
          shifted = (p.modifiers & ShiftMask) != 8'h00;
          for (int i = 0; i < KEY_SLOTS; i++) begin
            held = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++) begin
              if (held_keys[j] == keys[i]) held = 1'b1;
            end
            if (keys[i] != 8'h00 && !held) begin
              c = usage_to_code(keys[i], shifted);
              // A full ring keeps one slot free and drops the new code.
              if (c != 8'h00 && ring_codes.size() < RING_SLOTS - 1) begin
                ring_codes.push_back(c);
              end
            end
          end
          held_keys = keys;
        end
        if (ring_codes.size() != 0) begin
          want.code_valid = 1'b1;
          want.key_code   = ring_codes.pop_front();
        end
      end
      codes_due.push_back(want);
    endfunction

    task flag_mismatch(string what);
      $display("ERROR: %s", what);
      errors++;
    endtask

    // Compare one accepted result with the oldest expected one.
    task check_result(hidkb_out_t got);
      hidkb_out_t want;
      if (codes_due.size() == 0) begin
        flag_mismatch($sformatf("result %0b/%02h with nothing expected",
                                got.code_valid, got.key_code));
      end else begin
        want = codes_due.pop_front();
        if (got.code_valid !== want.code_valid) begin
          flag_mismatch($sformatf("code_valid %0b, expected %0b",
                                  got.code_valid, want.code_valid));
        end
        if (got.key_code !== want.key_code) begin
          flag_mismatch($sformatf("key_code %02h, expected %02h",
                                  got.key_code, want.key_code));
        end
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  hidkb_in_t  in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  hidkb_out_t out_data;

  keycode_scoreboard board = new();

  int unsigned tx_idle_odds = 0;
  int unsigned rx_idle_odds = 0;
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  logic [7:0]  typing [KEY_SLOTS] = '{default: 8'h00};

  hid_keyboard_report_to_keycodes_core #(
    .RING_DEPTH(RING_SLOTS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Result side: check accepted results, then decide on stalls.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (out_valid && out_ready) board.check_result(out_data);
        if (hold_request) begin
          hold_request = 1'b0;
          hold_left = PRESSURE_HOLD;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_ready <= 1'b0;
        end else if (rx_idle_odds != 0 && $urandom_range(1, rx_idle_odds) == 1) begin
          hold_left = $urandom_range(1, 16) - 1;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  function automatic hidkb_in_t make_poll(bit rr, logic [7:0] mods,
                                          logic [7:0] k0, logic [7:0] k1,
                                          logic [7:0] k2, logic [7:0] k3,
                                          logic [7:0] k4, logic [7:0] k5);
    hidkb_in_t p;
    p.report_ready = rr;
    p.modifiers    = mods;
    p.key_0 = k0;
    p.key_1 = k1;
    p.key_2 = k2;
    p.key_3 = k3;
    p.key_4 = k4;
    p.key_5 = k5;
    return p;
  endfunction

  // Mostly usages that translate, some navigation keys, a few anything.
  function automatic logic [7:0] pick_usage();
    logic [7:0] nav [9] = '{UsgRight, UsgLeft, UsgDown, UsgUp, UsgHome,
                            UsgEnd, UsgPageUp, UsgPageDown, UsgDelete};
    int unsigned roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return 8'($urandom_range(0, 255));
    if (roll < 3) return nav[$urandom_range(0, 8)];
    return 8'($urandom_range(8'h04, 8'h3E));
  endfunction

  // Typing model: keys are pressed and released a few at a time, so most
  // reports share usages with the previous one. One request in twenty is noise.
  function automatic hidkb_in_t next_poll();
    logic [63:0] raw;
    hidkb_in_t   p;
    int unsigned slot;
    if ($urandom_range(0, 19) == 0) begin
      raw = {$urandom, $urandom};
      p = raw[$bits(hidkb_in_t)-1:0];
      return p;
    end
    foreach (typing[i]) begin
      if ($urandom_range(0, 3) == 0) begin
        typing[i] = ($urandom_range(0, 2) == 0) ? 8'h00 : pick_usage();
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      slot = $urandom_range(1, KEY_SLOTS - 1);
      typing[slot] = typing[slot - 1];
    end
    p = make_poll($urandom_range(0, 4) != 0, 8'h00, typing[0], typing[1],
                  typing[2], typing[3], typing[4], typing[5]);
    case ($urandom_range(0, 4))
      0: p.modifiers = 8'h00;
      1: p.modifiers = 8'h02;
      2: p.modifiers = 8'h20;
      3: p.modifiers = ShiftMask;
      default: p.modifiers = 8'($urandom_range(0, 255));
    endcase
    return p;
  endfunction

  // Offer one poll request, with an optional gap first, and wait for it.
  task automatic send_poll(hidkb_in_t p);
    if (tx_idle_odds != 0 && $urandom_range(1, tx_idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
    board.note_poll(p);
  endtask

  task automatic send_random(int count, bit vary_idling);
    int unsigned odds [3] = '{0, 3, 8};
    for (int n = 0; n < count; n++) begin
      if (vary_idling && n % 50 == 0) begin
        tx_idle_odds = odds[$urandom_range(0, 2)];
        rx_idle_odds = odds[$urandom_range(0, 2)];
      end
      send_poll(next_poll());
    end
  endtask

  // Write the enable bit once every expected result has come back.
  task automatic set_keyboard(bit on);
    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= on;
    @(posedge clk);
    board.set_enabled(on);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Disabled out of reset: reports are ignored and every result carries no code.
    send_poll(make_poll(1, 8'hFF, 8'h04, 8'h05, 8'h4F, 8'h00, 8'hFF, 8'h2C));
    send_poll(make_poll(0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_poll(make_poll(1, 8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    set_keyboard(1'b1);

    // Directed requests over each translation range, both tables and the
    // navigation codes. The first 'a' must appear: disabled polls kept nothing.
    send_poll(make_poll(0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_poll(make_poll(1, 8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_poll(make_poll(1, 8'h02, 8'h04, 8'h1D, 8'h00, 8'h00, 8'h00, 8'h00));
    send_poll(make_poll(1, 8'h20, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23));
    send_poll(make_poll(1, 8'h22, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 8'h38));
    send_poll(make_poll(1, 8'hDD, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h31));
    send_poll(make_poll(1, 8'hFF, 8'h2E, 8'h2F, 8'h30, 8'h33, 8'h34, 8'h35));
    send_poll(make_poll(1, 8'h00, 8'h36, 8'h37, 8'h38, 8'h32, 8'h39, 8'h3A));
    send_poll(make_poll(1, 8'h00, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h00));
    send_poll(make_poll(1, 8'h00, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h4A, 8'h4D));
    send_poll(make_poll(1, 8'h22, 8'h4B, 8'h4E, 8'h4C, 8'h01, 8'h02, 8'h03));
    // The same usage six times in one report queues six codes.
    send_poll(make_poll(1, 8'h00, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05));
    send_poll(make_poll(1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_poll(make_poll(0, 8'h55, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
    repeat (6) begin
      send_poll(make_poll(0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    end

    // Random typing with changing amounts of idling on both sides.
    send_random(500, 1'b1);

    // Disabled again: the ring and the kept report must survive untouched.
    set_keyboard(1'b0);
    send_random(100, 1'b1);
    set_keyboard(1'b1);
    send_random(200, 1'b1);

    // Result side holds off for a long stretch while requests keep coming.
    tx_idle_odds = 0;
    hold_request = 1'b1;
    send_random(60, 1'b0);

    // Fill the ring past capacity: full reports alternate with empty ones,
    // each full report adding up to six new codes against one pop per poll.
    for (int n = 0; n < 60; n++) begin
      if (n % 2 == 0) begin
        send_poll(make_poll(1, ($urandom_range(0, 1) != 0) ? ShiftMask : 8'h00,
                            8'($urandom_range(8'h04, 8'h1D)),
                            8'($urandom_range(8'h04, 8'h1D)),
                            8'($urandom_range(8'h04, 8'h1D)),
                            8'($urandom_range(8'h04, 8'h1D)),
                            8'($urandom_range(8'h04, 8'h1D)),
                            8'($urandom_range(8'h04, 8'h1D))));
      end else begin
        send_poll(make_poll(1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      end
    end
    for (int n = 0; n < 80; n++) begin
      send_poll(make_poll(0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    end

    // Last part at full rate on both sides.
    tx_idle_odds = 0;
    rx_idle_odds = 0;
    send_random(450, 1'b0);

    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
